// ----- rtl/cmap_pkg.sv -----
package cmap_pkg;

	// Request commands.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Table formats held in the format register.
	localparam logic FMT_BYTE = 1'b0;
	localparam logic FMT_SEG  = 1'b1;

	// Largest table the word address can reach.
	localparam int MEM_DEPTH_MAX = 4096;

	// Byte format covers codes below this bound.
	localparam int BYTE_CODES = 256;

	// Width of the segment address arithmetic (holds 4*segs+4 and glyph sums).
	localparam int SEG_AW = 18;

	typedef logic [15:0] word_t;
	typedef logic [SEG_AW-1:0] seg_addr_t;

endpackage

// ----- rtl/cmap_glyph_index_lookup.sv -----
// Character-map glyph index lookup.
//
// Requests enter on start while busy is low. A write request (command 0)
// stores word_value at word_address and gives no result; a
// write at or beyond the table size is dropped. A lookup request (command 1)
// maps char_code and returns exactly one result on glyph_index, no_segment
// and address_fault, marked by a one-cycle done strobe.
// The format register (reset value: segmented) is written on the cfg channel
// when cfg_valid and cfg_ready are both high; cfg_ready is high while idle.
// A byte-format lookup reads the table word at char_code and then shows
// done; a code of 256 or more shows done with no read. A segmented lookup
// walks the segment arrays through the single-port table memory: it reads
// the header word, then two reads per segment (its end and start codes);
// on a match it reads the delta and range offset, and a glyph word when the
// range offset is not zero. An empty or oversized table ends after the
// header read. The memory read port has registered read data.
// Only one lookup is in flight; busy stays high until its result is issued,
// and the next request may be accepted in the cycle done is shown.
// Reset clears the control state and sets the segmented format; the table
// contents are undefined until written. The receiver cannot stall: each
// result is valid for exactly the one cycle done is high.
module cmap_glyph_index_lookup
	import cmap_pkg::*;
#(
	parameter int TABLE_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [11:0] word_address,
	input  logic [15:0] word_value,
	input  logic [15:0] char_code,
	output logic        done,
	output logic [15:0] glyph_index,
	output logic        no_segment,
	output logic        address_fault,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int USABLE = (TABLE_WORDS < MEM_DEPTH_MAX) ? TABLE_WORDS : MEM_DEPTH_MAX;
	localparam int AW = $clog2(USABLE);
	localparam seg_addr_t USABLE_W = SEG_AW'(USABLE);
	localparam logic [12:0] USABLE_13 = 13'(USABLE);
	localparam logic [15:0] BYTE_LIMIT = 16'(BYTE_CODES);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_BYTE      = 3'd1;
	localparam logic [2:0] ST_HDR       = 3'd2;
	localparam logic [2:0] ST_SEG_END   = 3'd3;
	localparam logic [2:0] ST_SEG_START = 3'd4;
	localparam logic [2:0] ST_DELTA     = 3'd5;
	localparam logic [2:0] ST_ROFF      = 3'd6;
	localparam logic [2:0] ST_GLYPH     = 3'd7;

	// Table memory, one port, registered read data.
	word_t mem_q [USABLE];
	word_t rdata_q;

	logic [2:0]  state_q, state_d;
	logic        format_q;
	logic [14:0] segs_q;
	logic [14:0] i_q;
	word_t       code_q, end_q, start_q, delta_q;
	seg_addr_t   roff_addr_q;
	logic        done_q, miss_q, fault_q;
	word_t       glyph_q;

	logic        accept, wr_en, rd_en;
	seg_addr_t   rd_addr;
	logic        emit, emit_miss, emit_fault;
	word_t       emit_glyph;
	logic        load_segs, clr_i, inc_i, load_end, load_start, load_delta, load_roff;
	logic [14:0] segs_rd;
	seg_addr_t   seg_limit, i_ext, segs_ext, roff_addr, glyph_addr;
	word_t       code_span;
	logic        in_seg;

	assign accept    = start && !busy;
	assign wr_en     = accept && (command == CMD_WRITE) && ({1'b0, word_address} < USABLE_13);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;

	// Address arithmetic for the segment arrays.
	assign segs_rd   = rdata_q[15:1];
	assign seg_limit = {1'b0, segs_rd, 2'b00} + SEG_AW'(4);
	assign i_ext     = {3'b000, i_q};
	assign segs_ext  = {3'b000, segs_q};
	assign roff_addr = {2'b00, segs_q, 1'b0} + segs_ext + SEG_AW'(5) + i_ext;
	assign code_span = code_q - start_q;
	assign glyph_addr = roff_addr_q + {3'b000, rdata_q[15:1]} + {2'b00, code_span};
	assign in_seg    = (code_q >= rdata_q) && (code_q <= end_q);

	// Sequencer: at most one table read per state, consumed in the following state.
	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = '0;
		emit       = 1'b0;
		emit_miss  = 1'b0;
		emit_fault = 1'b0;
		emit_glyph = '0;
		load_segs  = 1'b0;
		clr_i      = 1'b0;
		inc_i      = 1'b0;
		load_end   = 1'b0;
		load_start = 1'b0;
		load_delta = 1'b0;
		load_roff  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_LOOKUP) begin
					if (format_q == FMT_BYTE) begin
						if (char_code < BYTE_LIMIT) begin
							rd_en   = 1'b1;
							rd_addr = {2'b00, char_code};
							state_d = ST_BYTE;
						end else begin
							emit      = 1'b1;
							emit_miss = 1'b1;
						end
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_HDR;
					end
				end
			end
			ST_BYTE: begin
				emit       = 1'b1;
				emit_glyph = rdata_q;
				state_d    = ST_IDLE;
			end
			ST_HDR: begin
				if (segs_rd == '0) begin
					emit      = 1'b1;
					emit_miss = 1'b1;
					state_d   = ST_IDLE;
				end else if (seg_limit >= USABLE_W) begin
					emit       = 1'b1;
					emit_fault = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					load_segs = 1'b1;
					clr_i     = 1'b1;
					rd_en     = 1'b1;
					rd_addr   = SEG_AW'(4);
					state_d   = ST_SEG_END;
				end
			end
			ST_SEG_END: begin
				load_end = 1'b1;
				rd_en    = 1'b1;
				rd_addr  = segs_ext + SEG_AW'(5) + i_ext;
				state_d  = ST_SEG_START;
			end
			ST_SEG_START: begin
				if (in_seg) begin
					load_start = 1'b1;
					rd_en      = 1'b1;
					rd_addr    = {2'b00, segs_q, 1'b0} + SEG_AW'(5) + i_ext;
					state_d    = ST_DELTA;
				end else if (i_q == segs_q - 15'd1) begin
					emit      = 1'b1;
					emit_miss = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					inc_i   = 1'b1;
					rd_en   = 1'b1;
					rd_addr = SEG_AW'(5) + i_ext;
					state_d = ST_SEG_END;
				end
			end
			ST_DELTA: begin
				load_delta = 1'b1;
				load_roff  = 1'b1;
				rd_en      = 1'b1;
				rd_addr    = roff_addr;
				state_d    = ST_ROFF;
			end
			ST_ROFF: begin
				if (rdata_q == '0) begin
					emit       = 1'b1;
					emit_glyph = code_q + delta_q;
					state_d    = ST_IDLE;
				end else if (glyph_addr >= USABLE_W) begin
					emit       = 1'b1;
					emit_fault = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = glyph_addr;
					state_d = ST_GLYPH;
				end
			end
			ST_GLYPH: begin
				emit       = 1'b1;
				emit_glyph = (rdata_q == '0) ? '0 : rdata_q + delta_q;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Table memory port: writes only while idle, so they never meet a read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[word_address[AW-1:0]] <= word_value;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr[AW-1:0]];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			format_q <= FMT_SEG;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (cfg_valid && cfg_ready) begin
				format_q <= cfg_data;
			end
		end
	end

	// Lookup working registers and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= char_code;
		end
		if (load_segs) begin
			segs_q <= segs_rd;
		end
		if (clr_i) begin
			i_q <= '0;
		end else if (inc_i) begin
			i_q <= i_q + 15'd1;
		end
		if (load_end) begin
			end_q <= rdata_q;
		end
		if (load_start) begin
			start_q <= rdata_q;
		end
		if (load_delta) begin
			delta_q <= rdata_q;
		end
		if (load_roff) begin
			roff_addr_q <= roff_addr;
		end
		if (emit) begin
			glyph_q <= emit_glyph;
			miss_q  <= emit_miss;
			fault_q <= emit_fault;
		end
	end

	assign done          = done_q;
	assign glyph_index   = glyph_q;
	assign no_segment    = miss_q;
	assign address_fault = fault_q;

endmodule

// ----- dv/cmap_glyph_index_lookup_tb.sv -----
module cmap_glyph_index_lookup_tb
	import cmap_pkg::*;
();

	localparam int TBL_WORDS    = 4096;
	localparam int IDLE_LIMIT   = 20000;
	localparam int TARGET_ITEMS = 1350;
	localparam int MAX_SEGS     = 40;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		logic [15:0] glyph;
		logic        no_seg;
		logic        fault;
	} glyph_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        command = CMD_WRITE;
	logic [11:0] word_address = '0;
	logic [15:0] word_value = '0;
	logic [15:0] char_code = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = FMT_SEG;
	logic        cfg_ready;
	logic        busy;
	logic        done;
	logic [15:0] glyph_index;
	logic        no_segment;
	logic        address_fault;

	// Shadow copy of the table and the format register.
	bit [15:0]     shadow_word [TBL_WORDS];
	bit            shadow_written [TBL_WORDS];
	logic          shadow_format = FMT_SEG;
	glyph_result_t glyph_q [$];

	// Code ranges of the segment table currently built.
	int seg_lo [MAX_SEGS];
	int seg_hi [MAX_SEGS];
	int seg_cnt = 0;

	int n_items = 0;
	int n_writes = 0;
	int n_lookups = 0;
	int n_cfg = 0;
	int n_hit = 0;
	int n_miss = 0;
	int n_fault = 0;
	int n_err = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	cmap_glyph_index_lookup #(
		.TABLE_WORDS(TBL_WORDS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.word_address (word_address),
		.word_value   (word_value),
		.char_code    (char_code),
		.done         (done),
		.glyph_index  (glyph_index),
		.no_segment   (no_segment),
		.address_fault(address_fault),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reads a shadow word and notes the first word needed that was never written.
	function automatic int peek_word(input int addr, inout int missing);
		if (!shadow_written[addr] && missing < 0) begin
			missing = addr;
		end
		return shadow_word[addr];
	endfunction

	// Computes the glyph a lookup of code gives from the shadow table.
	function automatic glyph_result_t predict_glyph(input int code, output int missing);
		glyph_result_t r;
		int segs, endc, startc, delta, roff_at, roff, at, g;
		r = '0;
		missing = -1;
		if (shadow_format == FMT_BYTE) begin
			if (code < BYTE_CODES) begin
				r.glyph = 16'(peek_word(code, missing));
			end else begin
				r.no_seg = 1'b1;
			end
			return r;
		end
		segs = peek_word(0, missing) >> 1;
		if (missing >= 0) return r;
		if (segs == 0) begin
			r.no_seg = 1'b1;
			return r;
		end
		if (4 * segs + 4 >= TBL_WORDS) begin
			r.fault = 1'b1;
			return r;
		end
		for (int i = 0; i < segs; i++) begin
			endc = peek_word(4 + i, missing);
			startc = peek_word(segs + 5 + i, missing);
			if (missing >= 0) return r;
			if (code <= endc && code >= startc) begin
				delta = peek_word(2 * segs + 5 + i, missing);
				roff_at = 3 * segs + 5 + i;
				roff = peek_word(roff_at, missing);
				if (missing >= 0) return r;
				if (roff == 0) begin
					r.glyph = 16'(code + delta);
				end else begin
					at = roff_at + roff / 2 + code - startc;
					if (at >= TBL_WORDS) begin
						r.fault = 1'b1;
					end else begin
						g = peek_word(at, missing);
						if (g != 0) g = g + delta;
						r.glyph = 16'(g);
					end
				end
				return r;
			end
		end
		r.no_seg = 1'b1;
		return r;
	endfunction

	function automatic int rand_word();
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 65535));
	endfunction

	// Sends one request in bursts with random gaps, and updates the shadow on acceptance.
	task automatic send_req(input logic cmd, input logic [11:0] addr, input logic [15:0] val,
			input logic [15:0] code);
		int gap;
		int missing;
		glyph_result_t r;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0) gap = 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) :
				$urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		command <= cmd;
		word_address <= addr;
		word_value <= val;
		char_code <= code;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		n_items++;
		if (cmd == CMD_WRITE) begin
			shadow_word[addr] = val;
			shadow_written[addr] = 1'b1;
			n_writes++;
		end else begin
			r = predict_glyph(int'(code), missing);
			glyph_q.push_back(r);
			n_lookups++;
		end
	endtask

	task automatic write_word(input int addr, input int val);
		send_req(CMD_WRITE, 12'(addr), 16'(val), 16'($urandom));
	endtask

	// Fills every word the lookup would read that was never written, then looks up.
	task automatic lookup_code(input int code);
		int missing;
		void'(predict_glyph(code & 16'hFFFF, missing));
		while (missing >= 0) begin
			write_word(missing, rand_word());
			void'(predict_glyph(code & 16'hFFFF, missing));
		end
		send_req(CMD_LOOKUP, 12'($urandom), 16'($urandom), 16'(code));
	endtask

	// Holds requests off until every pending result is back and the block is quiet.
	task automatic wait_idle();
		start <= 1'b0;
		while (glyph_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_format(input logic fmt);
		wait_idle();
		cfg_data <= fmt;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_format = fmt;
		n_cfg++;
	endtask

	// Builds a segment table with mostly sorted ranges and mixed range offsets.
	task automatic build_seg_table(input int segs, input bit odd_count);
		int cursor, lo, hi, roff_at, roff, kind;
		write_word(0, 2 * segs + int'(odd_count));
		cursor = $urandom_range(0, 50000);
		seg_cnt = segs;
		for (int i = 0; i < segs; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				lo = $urandom_range(0, 65535);
				hi = $urandom_range(0, 65535);
			end else begin
				lo = cursor + $urandom_range(0, 300);
				hi = lo + (($urandom_range(0, 5) == 0) ? $urandom_range(16, 4000) :
					$urandom_range(0, 15));
				if (lo > 65535) lo = 65535;
				if (hi > 65535) hi = 65535;
				cursor = hi + 1;
			end
			seg_lo[i] = lo;
			seg_hi[i] = hi;
			roff_at = 3 * segs + 5 + i;
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				roff = 0;
			end else if (kind < 9) begin
				roff = 2 * (4 * segs + 5 + $urandom_range(0, 300) - roff_at) +
					$urandom_range(0, 1);
			end else begin
				roff = $urandom_range(0, 65535) | 16'h2000;
			end
			write_word(4 + i, hi);
			write_word(segs + 5 + i, lo);
			write_word(2 * segs + 5 + i, $urandom_range(0, 65535));
			write_word(roff_at, roff);
		end
	endtask

	// Mostly codes inside a segment, some on its edges, some anywhere.
	function automatic int pick_code();
		int i, k;
		k = $urandom_range(0, 9);
		if (seg_cnt == 0 || k >= 8) return $urandom_range(0, 65535);
		i = $urandom_range(0, seg_cnt - 1);
		if (k < 7) return $urandom_range(seg_lo[i], seg_hi[i]);
		return ($urandom_range(0, 1) == 0) ? (seg_lo[i] - 1) & 16'hFFFF :
			(seg_hi[i] + 1) & 16'hFFFF;
	endfunction

	// Two segments: a direct map with delta wrap, and an indexed glyph array.
	task automatic test_segment_map();
		set_format(FMT_SEG);
		write_word(0, 4);
		write_word(4, 16'h0040);
		write_word(5, 16'hFFFF);
		write_word(7, 16'h0020);
		write_word(8, 16'hFFF0);
		write_word(9, 16'hFFF0);
		write_word(10, 16'h0010);
		write_word(11, 0);
		write_word(12, 4);
		write_word(14, 16'h1234);
		write_word(15, 0);
		lookup_code(16'h0020);
		lookup_code(16'h0040);
		lookup_code(16'h0000);
		lookup_code(16'hFFF0);
		lookup_code(16'hFFF1);
		lookup_code(16'hFFFF);
	endtask

	// Glyph address past the table, zero and odd segment counts, oversized arrays.
	task automatic test_segment_corners();
		write_word(12, 16'hFFFE);
		lookup_code(16'hFFF5);
		write_word(0, 1);
		lookup_code(16'h0030);
		write_word(0, 5);
		lookup_code(16'h0030);
		write_word(0, 2046);
		lookup_code(16'h0030);
		write_word(0, 16'hFFFF);
		lookup_code(16'h0000);
		write_word(TBL_WORDS - 1, 16'hFFFF);
	endtask

	// Byte format: the edges of the code range and codes past it.
	task automatic test_byte_format();
		set_format(FMT_BYTE);
		write_word(255, 16'hFFFF);
		lookup_code(255);
		lookup_code(0);
		lookup_code(256);
		lookup_code(16'hFFFF);
	endtask

	// Phases of table builds and lookups in both formats, with stray writes mixed in.
	task automatic test_random_mix();
		int n;
		while (n_items < TARGET_ITEMS) begin
			n = $urandom_range(20, 60);
			if ($urandom_range(0, 3) == 0) begin
				if (shadow_format != FMT_BYTE) set_format(FMT_BYTE);
				for (int j = 0; j < n; j++) begin
					if ($urandom_range(0, 5) == 0) begin
						write_word($urandom_range(0, BYTE_CODES - 1), rand_word());
					end else if ($urandom_range(0, 7) == 0) begin
						lookup_code($urandom_range(0, 65535));
					end else begin
						lookup_code($urandom_range(0, BYTE_CODES - 1));
					end
				end
			end else begin
				if (shadow_format != FMT_SEG) set_format(FMT_SEG);
				build_seg_table(($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_SEGS) :
					$urandom_range(1, 8), $urandom_range(0, 3) == 0);
				for (int j = 0; j < n; j++) begin
					if ($urandom_range(0, 11) == 0) begin
						write_word($urandom_range(0, TBL_WORDS - 1), $urandom_range(0, 65535));
					end else begin
						lookup_code(pick_code());
					end
				end
			end
			if ($urandom_range(0, 3) == 0) wait_idle();
		end
	endtask

	task automatic report_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		n_err++;
		if (n_err <= MAX_REPORTS) begin
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
		end
	endtask

	// Each result is compared with the oldest pending lookup.
	always @(posedge clk) begin : check_result
		glyph_result_t want;
		if (arst_n && done === 1'b1) begin
			if (glyph_q.size() == 0) begin
				n_err++;
				if (n_err <= MAX_REPORTS) begin
					$display("%0t: result with no lookup pending, expected none actual %h",
						$time, glyph_index);
				end
			end else begin
				want = glyph_q.pop_front();
				if (glyph_index !== want.glyph) report_field("glyph_index", want.glyph,
					glyph_index);
				if (no_segment !== want.no_seg) report_field("no_segment", 16'(want.no_seg),
					16'(no_segment));
				if (address_fault !== want.fault) report_field("address_fault",
					16'(want.fault), 16'(address_fault));
				if (want.fault) n_fault++;
				else if (want.no_seg) n_miss++;
				else n_hit++;
			end
		end
	end

	// Ends the run when no request, result or register write moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_segment_map();
		test_segment_corners();
		test_byte_format();
		test_random_mix();
		wait_idle();
		repeat (8) @(posedge clk);
		if (glyph_q.size() != 0) begin
			$display("%0t: %0d lookups never returned a result", $time, glyph_q.size());
			n_err += glyph_q.size();
		end
		$display("Sent %0d requests: %0d table writes, %0d lookups, %0d format writes.",
			n_items, n_writes, n_lookups, n_cfg);
		$display("Lookups gave %0d mapped glyphs, %0d uncovered codes, %0d address faults.",
			n_hit, n_miss, n_fault);
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
